// ----- sv/tms_pkg.sv -----
// shared types, register map and filter arithmetic for the tilt monitor smoothing unit
package tms_pkg;

	// register map, word index into the apb space
	localparam logic [2:0] REG_OFFSET_X      = 3'd0;
	localparam logic [2:0] REG_OFFSET_Z      = 3'd1;
	localparam logic [2:0] REG_ERR_SET_TOL   = 3'd2;
	localparam logic [2:0] REG_ERR_CLEAR_TOL = 3'd3;
	localparam logic [2:0] REG_STAND_TOL     = 3'd4;
	localparam logic [2:0] REG_RECOVER_TICKS = 3'd5;

	localparam int unsigned ADDR_W = 5;

	// register reset values
	localparam logic [14:0] ERR_SET_TOL_RST   = 15'd3277;
	localparam logic [14:0] ERR_CLEAR_TOL_RST = 15'd2458;
	localparam logic [14:0] STAND_TOL_RST     = 15'd1638;
	localparam logic [15:0] RECOVER_TICKS_RST = 16'd300;

	// one g at full state precision (4096 << 8)
	localparam logic signed [24:0] ONE_G_FULL = 25'sd1048576;

	// reciprocal of ten, exact for 32-bit dividends at shift 35
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	localparam logic signed [23:0] S24_MAX = 24'sh7F_FFFF;
	localparam logic signed [23:0] S24_MIN = -24'sh80_0000;

	typedef struct packed {
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_z;
		logic [14:0]        err_set_tol;
		logic [14:0]        err_clear_tol;
		logic [14:0]        stand_tol;
		logic [15:0]        recover_ticks;
	} cfg_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} pipe_ctl_t;

	typedef struct packed {
		logic home_settled;
		logic in_bad_state;
	} tick_flags_t;

	// one filter step s + (t - s) / k, k = 10 or 20, quotient truncated toward zero
	function automatic logic signed [23:0] ema_step(input logic signed [23:0] s,
			input logic signed [23:0] t, input logic by20);
		logic signed [24:0] d;
		logic [24:0]        mag;
		logic [56:0]        prod;
		logic [24:0]        q;
		logic signed [24:0] r;
		logic signed [24:0] sum;
		d    = {t[23], t} - {s[23], s};
		mag  = d[24] ? 25'(-d) : 25'(d);
		prod = 57'(mag) * 57'(RECIP10);
		q    = by20 ? 25'(prod >> 36) : 25'(prod >> 35);
		r    = d[24] ? -$signed(q) : $signed(q);
		sum  = {s[23], s} + r;
		return sum[23:0];
	endfunction

	// target after offset removal, clamped to the signed 24-bit range
	function automatic logic signed [23:0] sub_offset(input logic signed [23:0] avg,
			input logic signed [15:0] off);
		logic signed [24:0] d;
		d = {avg[23], avg} - {off[15], off, 8'd0};
		if (d > 25'(S24_MAX))
			return S24_MAX;
		else if (d < 25'(S24_MIN))
			return S24_MIN;
		else
			return d[23:0];
	endfunction

endpackage

// ----- sv/tms_cfg.sv -----
// apb register file for offsets, tolerances and recovery count
module tms_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tms_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output tms_pkg::cfg_t                  cfg
);

	logic       wr_en;
	logic [2:0] idx;
	tms_pkg::cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x      <= '0;
			cfg_q.offset_z      <= '0;
			cfg_q.err_set_tol   <= tms_pkg::ERR_SET_TOL_RST;
			cfg_q.err_clear_tol <= tms_pkg::ERR_CLEAR_TOL_RST;
			cfg_q.stand_tol     <= tms_pkg::STAND_TOL_RST;
			cfg_q.recover_ticks <= tms_pkg::RECOVER_TICKS_RST;
		end else if (wr_en) begin
			unique case (idx)
				tms_pkg::REG_OFFSET_X:      cfg_q.offset_x      <= pwdata[15:0];
				tms_pkg::REG_OFFSET_Z:      cfg_q.offset_z      <= pwdata[15:0];
				tms_pkg::REG_ERR_SET_TOL:   cfg_q.err_set_tol   <= pwdata[14:0];
				tms_pkg::REG_ERR_CLEAR_TOL: cfg_q.err_clear_tol <= pwdata[14:0];
				tms_pkg::REG_STAND_TOL:     cfg_q.stand_tol     <= pwdata[14:0];
				tms_pkg::REG_RECOVER_TICKS: cfg_q.recover_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			tms_pkg::REG_OFFSET_X:      prdata = {16'd0, cfg_q.offset_x};
			tms_pkg::REG_OFFSET_Z:      prdata = {16'd0, cfg_q.offset_z};
			tms_pkg::REG_ERR_SET_TOL:   prdata = {17'd0, cfg_q.err_set_tol};
			tms_pkg::REG_ERR_CLEAR_TOL: prdata = {17'd0, cfg_q.err_clear_tol};
			tms_pkg::REG_STAND_TOL:     prdata = {17'd0, cfg_q.stand_tol};
			tms_pkg::REG_RECOVER_TICKS: prdata = {16'd0, cfg_q.recover_ticks};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

// ----- sv/tms_filter.sv -----
// two filter stages: raw averages and arm angle, then offset-corrected smoothing
module tms_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tms_pkg::pipe_ctl_t        ctl,
	input  logic signed [15:0]        accel_x,
	input  logic signed [15:0]        accel_z,
	input  logic signed [15:0]        arm_angle,
	input  tms_pkg::tick_flags_t      flags_in,
	input  logic signed [15:0]        offset_x,
	input  logic signed [15:0]        offset_z,
	output logic signed [23:0]        smooth_x,
	output logic signed [23:0]        smooth_y,
	output logic signed [23:0]        smooth_z,
	output tms_pkg::tick_flags_t      flags_out
);

	logic signed [23:0] avg_x_q, avg_z_q, smooth_y_q;
	logic signed [23:0] smooth_x_q, smooth_z_q, y_s2;
	tms_pkg::tick_flags_t flags_s1, flags_s2;

	// stage 1: filter state that reads the raw sample only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_x_q    <= '0;
			avg_z_q    <= '0;
			smooth_y_q <= '0;
		end else if (ctl.load_s1) begin
			avg_x_q    <= tms_pkg::ema_step(avg_x_q, {accel_x, 8'd0}, 1'b0);
			avg_z_q    <= tms_pkg::ema_step(avg_z_q, {accel_z, 8'd0}, 1'b0);
			smooth_y_q <= tms_pkg::ema_step(smooth_y_q, {arm_angle, 8'd0}, 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1)
			flags_s1 <= flags_in;
	end

	// stage 2: offset removal and second smoothing of x and z
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_x_q <= '0;
			smooth_z_q <= '0;
		end else if (ctl.load_s2) begin
			smooth_x_q <= tms_pkg::ema_step(smooth_x_q,
				tms_pkg::sub_offset(avg_x_q, offset_x), 1'b0);
			smooth_z_q <= tms_pkg::ema_step(smooth_z_q,
				tms_pkg::sub_offset(avg_z_q, offset_z), 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			y_s2     <= smooth_y_q;
			flags_s2 <= flags_s1;
		end
	end

	assign smooth_x  = smooth_x_q;
	assign smooth_y  = y_s2;
	assign smooth_z  = smooth_z_q;
	assign flags_out = flags_s2;

endmodule

// ----- sv/tms_monitor.sv -----
// result register with tilt hysteresis, recovery timer and standing check
module tms_monitor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic signed [23:0]        smooth_x,
	input  logic signed [23:0]        smooth_y,
	input  logic signed [23:0]        smooth_z,
	input  tms_pkg::tick_flags_t      flags,
	input  tms_pkg::cfg_t             cfg,
	output logic signed [15:0]        filt_x,
	output logic signed [15:0]        filt_y,
	output logic signed [15:0]        filt_z,
	output logic                      tilt_error,
	output logic                      go_bad_orientation,
	output logic                      go_home,
	output logic                      standing,
	output logic                      standing_changed
);

	logic        err_q, seen_q, stand_last_q;
	logic [15:0] clear_cnt_q;
	logic [15:0] fx_q, fy_q, fz_q;
	logic        go_bad_q, go_home_q, changed_q;

	logic [23:0]        abs_y, abs_x;
	logic signed [24:0] z_up;
	logic [24:0]        abs_z;
	logic [22:0]        set_t, clr_t, st_t;
	logic               err_nx, seen_nx, go_bad_nx, go_home_nx, stand_nx;
	logic [15:0]        cnt_nx;

	// tilt hysteresis, onset pulse and recovery count
	always_comb begin
		abs_y = smooth_y[23] ? 24'(-smooth_y) : 24'(smooth_y);
		set_t = {cfg.err_set_tol, 8'd0};
		clr_t = {cfg.err_clear_tol, 8'd0};
		if (err_q)
			err_nx = abs_y > 24'(clr_t);
		else if (flags.home_settled)
			err_nx = abs_y > 24'(set_t);
		else
			err_nx = 1'b0;

		seen_nx   = seen_q;
		go_bad_nx = 1'b0;
		cnt_nx    = clear_cnt_q;
		if (err_nx && !seen_q) begin
			seen_nx   = 1'b1;
			go_bad_nx = 1'b1;
		end
		if (!err_nx) begin
			if (seen_q) begin
				seen_nx = 1'b0;
				cnt_nx  = '0;
			end else if (clear_cnt_q != 16'hFFFF) begin
				cnt_nx = clear_cnt_q + 16'd1;
			end
		end
		go_home_nx = !err_nx && (cnt_nx >= cfg.recover_ticks) && flags.in_bad_state;
	end

	// lying-flat check: x near zero and z near minus one g
	always_comb begin
		abs_x    = smooth_x[23] ? 24'(-smooth_x) : 24'(smooth_x);
		z_up     = {smooth_z[23], smooth_z} + tms_pkg::ONE_G_FULL;
		abs_z    = z_up[24] ? 25'(-z_up) : 25'(z_up);
		st_t     = {cfg.stand_tol, 8'd0};
		stand_nx = !((abs_x <= 24'(st_t)) && (abs_z <= 25'(st_t)));
	end

	// monitor state and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q        <= 1'b0;
			seen_q       <= 1'b0;
			stand_last_q <= 1'b0;
			clear_cnt_q  <= '0;
			go_bad_q     <= 1'b0;
			go_home_q    <= 1'b0;
			changed_q    <= 1'b0;
		end else if (load) begin
			err_q        <= err_nx;
			seen_q       <= seen_nx;
			stand_last_q <= stand_nx;
			clear_cnt_q  <= cnt_nx;
			go_bad_q     <= go_bad_nx;
			go_home_q    <= go_home_nx;
			changed_q    <= stand_nx != stand_last_q;
		end
	end

	// filter outputs floored to the input format
	always_ff @(posedge clk) begin
		if (load) begin
			fx_q <= smooth_x[23:8];
			fy_q <= smooth_y[23:8];
			fz_q <= smooth_z[23:8];
		end
	end

	assign filt_x             = fx_q;
	assign filt_y             = fy_q;
	assign filt_z             = fz_q;
	assign tilt_error         = err_q;
	assign go_bad_orientation = go_bad_q;
	assign go_home            = go_home_q;
	assign standing           = stand_last_q;
	assign standing_changed   = changed_q;

	// onset pulse only comes with a raised error
	a_bad_needs_err: assert property (@(posedge clk) disable iff (!arst_n)
		go_bad_q |-> err_q) else $error("onset pulse without tilt error");

	// home request only while the error is clear
	a_home_needs_clear: assert property (@(posedge clk) disable iff (!arst_n)
		go_home_q |-> !err_q) else $error("home request during tilt error");

	// an error onset sets the seen mark in the same tick
	a_seen_follows: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> seen_q) else $error("error flag set but onset not recorded");

	// counter restarts when an error episode ends
	a_cnt_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$past(load) && $past(seen_q) && !err_q |-> clear_cnt_q == 16'd0)
		else $error("clear count not restarted after error");

endmodule

// ----- sv/tilt_monitor_smoothing_unit.sv -----
// top level: stream ports, pipeline handshake and apb configuration
// a beat accepted into stage one moves on through stage two into the result register
// throughput: one beat per cycle while m_tready holds; stages advance independently, so bubbles close up
// the result register holds a finished beat while new beats fill the empty stages behind it
// reset: arst_n clears all filter state, error and recovery state and the valid bits,
// and loads the register defaults
module tilt_monitor_smoothing_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// apb configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tms_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [47:0]                    s_tdata,  // accel_x, accel_z, arm_angle
	input  logic [1:0]                     s_tuser,  // home_settled, in_bad_state
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [47:0]                    m_tdata,  // filt_x, filt_y, filt_z
	output logic [4:0]                     m_tuser   // tilt_error, go_bad_orientation,
	                                                 // go_home, standing, standing_changed
);

	tms_pkg::cfg_t        cfg;
	tms_pkg::pipe_ctl_t   ctl;
	tms_pkg::tick_flags_t flags_in, flags_s2;

	logic v1_q, v2_q, vout_q;
	logic en1, en2, en_out, load_out;
	logic signed [23:0] sx, sy, sz;
	logic signed [15:0] fx, fy, fz;
	logic err, go_bad, go_home_o, stand, stand_chg;

	// per-stage advance: a stage moves when the one after it is free or moving
	assign en_out   = !vout_q || m_tready;
	assign en2      = !v2_q || en_out;
	assign en1      = !v1_q || en2;
	assign s_tready = en1;

	assign ctl.load_s1 = s_tvalid && en1;
	assign ctl.load_s2 = v1_q && en2;
	assign load_out    = v2_q && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			vout_q <= 1'b0;
		end else begin
			if (en1)
				v1_q <= s_tvalid;
			if (en2)
				v2_q <= v1_q;
			if (en_out)
				vout_q <= v2_q;
		end
	end

	assign flags_in.home_settled = s_tuser[0];
	assign flags_in.in_bad_state = s_tuser[1];

	tms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tms_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.accel_x   (s_tdata[15:0]),
		.accel_z   (s_tdata[31:16]),
		.arm_angle (s_tdata[47:32]),
		.flags_in  (flags_in),
		.offset_x  (cfg.offset_x),
		.offset_z  (cfg.offset_z),
		.smooth_x  (sx),
		.smooth_y  (sy),
		.smooth_z  (sz),
		.flags_out (flags_s2)
	);

	tms_monitor u_monitor (
		.clk                (clk),
		.arst_n             (arst_n),
		.load               (load_out),
		.smooth_x           (sx),
		.smooth_y           (sy),
		.smooth_z           (sz),
		.flags              (flags_s2),
		.cfg                (cfg),
		.filt_x             (fx),
		.filt_y             (fy),
		.filt_z             (fz),
		.tilt_error         (err),
		.go_bad_orientation (go_bad),
		.go_home            (go_home_o),
		.standing           (stand),
		.standing_changed   (stand_chg)
	);

	assign m_tvalid = vout_q;
	assign m_tdata  = {fz, fy, fx};
	assign m_tuser  = {stand_chg, stand, go_home_o, go_bad, err};

	// an empty result register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vout_q |-> s_tready) else $error("input stalled with empty result register");

	// a waiting result is not overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		vout_q && !m_tready |-> !load_out) else $error("result overwritten while stalled");

	// a beat in stage two reaches the result register when it is free
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q && !vout_q |=> vout_q) else $error("stage two beat not moved to result");

endmodule
